/* rtl/apnv_pkg.sv */
package apnv_pkg;

    // Status codes reported on the last item of a name
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_EMPTY      = 3'd1;
    localparam logic [2:0] ST_LEAD_SLASH = 3'd2;
    localparam logic [2:0] ST_BACKSLASH  = 3'd3;
    localparam logic [2:0] ST_EMPTY_SEG  = 3'd4;
    localparam logic [2:0] ST_BAD_CHAR   = 3'd5;
    localparam logic [2:0] ST_TRAIL      = 3'd6;
    localparam logic [2:0] ST_RESERVED   = 3'd7;

    // Character constants
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CTRL   = 8'h20;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    // Reserved device bases, first byte in the low bits
    localparam logic [23:0] RES_CON = 24'h4E4F43;
    localparam logic [23:0] RES_PRN = 24'h4E5250;
    localparam logic [23:0] RES_AUX = 24'h585541;
    localparam logic [23:0] RES_NUL = 24'h4C554E;
    localparam logic [23:0] RES_COM = 24'h4D4F43;
    localparam logic [23:0] RES_LPT = 24'h54504C;

    localparam logic [2:0] LEN_MAX  = 3'd7;
    localparam logic [2:0] BASE_CAP = 3'd4;

    // One classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] upper;
        logic       is_zero;
        logic       is_slash;
        logic       is_bslash;
        logic       is_dot;
        logic       is_space;
        logic       is_bad;
        logic       last;
    } item_t;

    // Per-segment scan state
    typedef struct packed {
        logic [2:0]  seg_len;
        logic [2:0]  base_len;
        logic        dot_seen;
        logic        bad_char;
        logic        all_dots;
        logic        last_dot;
        logic        last_space;
        logic [31:0] base_chars;
    } seg_t;

    // Queue status seen by the back end and the top level
    typedef struct packed {
        logic full;
        logic empty;
    } qst_t;

    localparam seg_t SEG_CLEAR = '{
        seg_len: 3'd0, base_len: 3'd0, dot_seen: 1'b0, bad_char: 1'b0,
        all_dots: 1'b1, last_dot: 1'b0, last_space: 1'b0, base_chars: 32'd0
    };

    function automatic logic is_reserved(input seg_t s);
        logic [23:0] low3;
        logic [7:0]  d;
        logic        res;
        low3 = s.base_chars[23:0];
        d    = s.base_chars[31:24];
        res  = 1'b0;
        if (s.base_len == 3'd3) begin
            res = (low3 == RES_CON) || (low3 == RES_PRN) ||
                  (low3 == RES_AUX) || (low3 == RES_NUL);
        end else if (s.base_len == 3'd4) begin
            res = (d >= CH_ONE) && (d <= CH_NINE) &&
                  ((low3 == RES_COM) || (low3 == RES_LPT));
        end
        return res;
    endfunction

    function automatic logic [2:0] seg_code(input seg_t s);
        logic [2:0] code;
        if (s.seg_len == 3'd0) begin
            code = ST_EMPTY_SEG;
        end else if (s.all_dots && (s.seg_len <= 3'd2)) begin
            code = ST_BAD_CHAR;
        end else if (s.bad_char) begin
            code = ST_BAD_CHAR;
        end else if (s.last_dot || s.last_space) begin
            code = ST_TRAIL;
        end else if (is_reserved(s)) begin
            code = ST_RESERVED;
        end else begin
            code = ST_OK;
        end
        return code;
    endfunction

    function automatic seg_t add_char(input seg_t s, input item_t it);
        seg_t n;
        n = s;
        if (s.seg_len < LEN_MAX) n.seg_len = s.seg_len + 3'd1;
        if (!it.is_dot) n.all_dots = 1'b0;
        if (it.is_bad) n.bad_char = 1'b1;
        n.last_dot   = it.is_dot;
        n.last_space = it.is_space;
        if (!s.dot_seen) begin
            if (it.is_dot) begin
                n.dot_seen = 1'b1;
            end else begin
                if (s.base_len < BASE_CAP) begin
                    n.base_chars[{s.base_len[1:0], 3'b000} +: 8] = it.upper;
                end
                if (s.base_len < LEN_MAX) n.base_len = s.base_len + 3'd1;
            end
        end
        return n;
    endfunction

endpackage

/* rtl/asset_path_name_validator.sv */
// Asset path name validator.
// Input channel (s_valid/s_ready): one byte of a slash-separated name per
// item in s_char_byte; s_last marks the final item of a name. A zero byte
// ends the name; bytes after it are ignored until the last item.
// Result channel (m_valid/m_ready): one 3-bit m_status per name, sent for
// the item marked last (0 ok, 1 empty, 2 leading slash, 3 backslash,
// 4 empty segment, 5 invalid char, 6 trailing dot/space, 7 reserved).
// Throughput: one item per cycle while the queue is not full. A front stage
// classifies each byte into a QueueDepth-entry queue; the back end scans one
// queued item per cycle, except that a last item waits while an earlier
// status is still unaccepted. The status is registered when the last item
// is popped, after any items queued ahead of it. When m_ready is low the
// status is held; bytes that are not last keep draining, and input is still taken until the queue fills.
// Reset (aresetn low, synchronous) empties the queue, drops any pending
// status and clears the scan state so the next byte starts a new name.
module asset_path_name_validator #(
    parameter int QueueDepth = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_byte,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status
);
    import apnv_pkg::*;

    item_t in_item;
    item_t q_item;
    qst_t  qst;
    logic  push;
    logic  pop;

    assign s_ready = !qst.full;
    assign push    = s_valid && s_ready;

    apnv_front u_front (
        .s_char_byte (s_char_byte),
        .s_last      (s_last),
        .item        (in_item)
    );

    apnv_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (in_item),
        .pop       (pop),
        .pop_item  (q_item),
        .qst       (qst)
    );

    apnv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qst      (qst),
        .q_item   (q_item),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status)
    );

`ifndef SYNTH
    // Reset leaves the queue empty and no status pending
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> (qst.empty && !m_valid))
        else $error("queue or output not cleared by reset");

    // An item taken without a pop leaves the queue non-empty
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> !qst.empty)
        else $error("accepted item lost in queue");

    // Full and empty never hold together
    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(qst.full && qst.empty))
        else $error("queue full and empty at once");

    // A status appears only after a last item was popped
    a_status_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(pop && q_item.last))
        else $error("status raised without a last item");
`endif

endmodule

/* rtl/apnv_front.sv */
module apnv_front (
    input  logic [7:0]           s_char_byte,
    input  logic                 s_last,
    output apnv_pkg::item_t      item
);
    import apnv_pkg::*;

    logic [7:0] c;

    assign c = s_char_byte;

    // Classify the byte once so the back end only tests flags
    always_comb begin
        item.upper     = ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ? (c - CASE_BIT) : c;
        item.is_zero   = (c == 8'd0);
        item.is_slash  = (c == CH_SLASH);
        item.is_bslash = (c == CH_BSLASH);
        item.is_dot    = (c == CH_DOT);
        item.is_space  = (c == CH_SPACE);
        item.is_bad    = (c < CH_CTRL) || (c == CH_LT) || (c == CH_GT) ||
                         (c == CH_COLON) || (c == CH_QUOTE) || (c == CH_PIPE) ||
                         (c == CH_QMARK) || (c == CH_STAR);
        item.last      = s_last;
    end

endmodule

/* rtl/apnv_queue.sv */
module apnv_queue #(
    parameter int Depth = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  apnv_pkg::item_t      push_item,
    input  logic                 pop,
    output apnv_pkg::item_t      pop_item,
    output apnv_pkg::qst_t       qst
);
    import apnv_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    item_t           mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    // Advance pointers with explicit wrap and track fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)  rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (!push && pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item
    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_item;
    end

    assign pop_item  = mem[rd_ptr_reg];
    assign qst.full  = (count_reg == CntFull);
    assign qst.empty = (count_reg == '0);

endmodule

/* rtl/apnv_back.sv */
module apnv_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  apnv_pkg::qst_t       qst,
    input  apnv_pkg::item_t      q_item,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status
);
    import apnv_pkg::*;

    logic       first_reg, first_next;
    logic       ended_reg, ended_next;
    logic [2:0] err_reg, err_next;
    seg_t       seg_reg, seg_next;
    logic       m_valid_reg, m_valid_next;
    logic [2:0] m_status_reg;
    logic [2:0] final_code;
    logic       f1, e1;
    logic [2:0] r1;
    seg_t       s1;

    // Take an item unless it would report into a stalled output register
    assign pop = !qst.empty && (!q_item.last || !m_valid_reg || m_ready);

    // Scan the byte, then close the name if this is the last item
    always_comb begin
        f1 = first_reg;
        e1 = ended_reg;
        r1 = err_reg;
        s1 = seg_reg;
        if (!ended_reg && (err_reg == ST_OK)) begin
            if (first_reg) f1 = 1'b0;
            if (first_reg && q_item.is_zero) begin
                r1 = ST_EMPTY;
                e1 = 1'b1;
            end else if (first_reg && q_item.is_slash) begin
                r1 = ST_LEAD_SLASH;
            end else if (q_item.is_zero) begin
                r1 = seg_code(seg_reg);
                e1 = 1'b1;
            end else if (q_item.is_bslash) begin
                r1 = ST_BACKSLASH;
            end else if (q_item.is_slash) begin
                r1 = seg_code(seg_reg);
                s1 = SEG_CLEAR;
            end else begin
                s1 = add_char(seg_reg, q_item);
            end
        end
        // Implied terminator on the last item
        final_code = r1;
        if (!e1 && (r1 == ST_OK)) begin
            final_code = f1 ? ST_EMPTY : seg_code(s1);
        end

        first_next = first_reg;
        ended_next = ended_reg;
        err_next   = err_reg;
        seg_next   = seg_reg;
        if (pop) begin
            if (q_item.last) begin
                first_next = 1'b1;
                ended_next = 1'b0;
                err_next   = ST_OK;
                seg_next   = SEG_CLEAR;
            end else begin
                first_next = f1;
                ended_next = e1;
                err_next   = r1;
                seg_next   = s1;
            end
        end

        m_valid_next = m_valid_reg;
        if (pop && q_item.last) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg   <= 1'b1;
            ended_reg   <= 1'b0;
            err_reg     <= ST_OK;
            seg_reg     <= SEG_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            first_reg   <= first_next;
            ended_reg   <= ended_next;
            err_reg     <= err_next;
            seg_reg     <= seg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the status until taken
    always_ff @(posedge aclk) begin
        if (pop && q_item.last) m_status_reg <= final_code;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

endmodule
